// ----- sv/affc_pkg.sv -----
// ----------------------------------------------------------------------------
// Adaptive flat-field correction - shared package
// Command codes, register indexes, fixed constants and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package affc_pkg;

    localparam logic [2:0] CMD_SAMPLE    = 3'd0;
    localparam logic [2:0] CMD_CORRECT   = 3'd1;
    localparam logic [2:0] CMD_WR_TABLE  = 3'd2;
    localparam logic [2:0] CMD_READ_HP   = 3'd3;
    localparam logic [2:0] CMD_PEAK      = 3'd4;

    localparam logic       REG_CORRECTION   = 1'b0;
    localparam logic       REG_COMPENSATION = 1'b1;

    localparam logic [8:0] HP_MARGIN  = 9'd5;
    localparam logic [7:0] HP_MIN     = 8'd28;
    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam int         AGE_INIT   = 3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_DIV,
        ST_LOOKUP,
        ST_CORR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ----- sv/affc_divider.sv -----
// ----------------------------------------------------------------------------
// Adaptive flat-field correction - restoring divider
// One quotient bit per cycle, eight-bit quotient, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module affc_divider (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [16:0]          numer,
    input  wire logic [8:0]           denom,
    output logic [7:0]                quot,
    output affc_pkg::div_status_t     status
);

    logic [16:0] rem_reg,  rem_next;
    logic [8:0]  den_reg,  den_next;
    logic [2:0]  bit_reg,  bit_next;
    logic [7:0]  quot_reg, quot_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;

    always_comb begin
        shifted   = {8'd0, den_reg} << bit_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bit_next  = bit_reg;
        quot_next = quot_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = numer;
            den_next  = denom;
            bit_next  = 3'd7;
            quot_next = 8'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= shifted) begin
                rem_next           = rem_reg - shifted;
                quot_next[bit_reg] = 1'b1;
            end
            bit_next = bit_reg - 3'd1;
            if (bit_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bit_reg  <= bit_next;
        quot_reg <= quot_next;
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ----- sv/adaptive_flat_field_correction_top.sv -----
// ----------------------------------------------------------------------------
// Adaptive flat-field correction - top level
// Per-column high-point tracking over a history ring and pixel correction.
// ----------------------------------------------------------------------------
// One item at a time. Sample commands may recompute the high point from the
// history (one history read per cycle); peak commands search the most recent
// min(recent_lines, SAMPLE_LINES) lines; corrections use an eight-step
// divider. A result held back by m_ready delays the next transfer.
// After reset a clearing pass over all SAMPLE_LINES * 2**ceil(log2(LINE_WIDTH))
// history entries sets the history to 255 before the first transfer is taken.
`default_nettype none

module adaptive_flat_field_correction_top #(
    parameter int LINE_WIDTH   = 2048,
    parameter int SAMPLE_LINES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [10:0] s_column,
    input  wire logic [7:0]  s_pixel,
    input  wire logic        s_line_start,
    input  wire logic [4:0]  s_recent_lines,
    input  wire logic [7:0]  s_table_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [10:0]      m_result_column,
    output logic [7:0]       m_result_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    localparam int CW   = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam int RW   = $clog2(SAMPLE_LINES);
    localparam int HAW  = RW + CW;
    localparam int HPD  = 2 ** CW;
    localparam int HD   = SAMPLE_LINES * HPD;
    localparam int AW   = $clog2(SAMPLE_LINES + 2);
    localparam int GW   = $clog2(SAMPLE_LINES + 1);

    logic [7:0]        hist_mem [HD];
    logic [AW+7:0]     hp_mem   [HPD];
    logic [7:0]        tbl_mem  [256];

    affc_pkg::state_t  state_reg, state_next;
    logic [HAW-1:0]    clr_reg, clr_next;
    logic [RW-1:0]     row_reg, row_next;
    logic              corr_on_reg, comp_on_reg;
    logic [2:0]        cmd_reg, cmd_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [10:0]       colp_reg, colp_next;
    logic [7:0]        pix_reg, pix_next;
    logic [GW-1:0]     n_reg, n_next;
    logic [GW-1:0]     cnt_reg, cnt_next;
    logic [RW-1:0]     srow_reg, srow_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [GW-1:0]     rd_age_reg, rd_age_next;
    logic [7:0]        t0_reg, t1_reg, t2_reg, t0_next, t1_next, t2_next;
    logic [GW-1:0]     g0_reg, g1_reg, g2_reg, g0_next, g1_next, g2_next;
    logic              zero_age_reg, zero_age_next;
    logic [7:0]        s_reg, s_next;
    logic [7:0]        res_reg, res_next;
    logic              m_valid_reg;
    logic [10:0]       m_col_reg;
    logic [7:0]        m_val_reg;

    logic              hist_we, hp_we, tbl_we, div_start, out_load, issue;
    logic [HAW-1:0]    hist_waddr;
    logic [7:0]        hist_wdata, hist_q, tbl_q;
    logic [CW-1:0]     hp_waddr, hp_raddr, s_col_idx;
    logic [AW+7:0]     hp_wdata, hp_q;
    logic [7:0]        hp;
    logic [AW-1:0]     age, age_inc;
    logic              accept, col_ok;
    logic [7:0]        quot;
    affc_pkg::div_status_t div_stat;

    affc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (({9'd0, pix_reg} << 9) - ({9'd0, pix_reg} << 1) + {9'd0, hp}),
        .denom   ({hp, 1'b0}),
        .quot    (quot),
        .status  (div_stat)
    );

    assign s_ready   = (state_reg == affc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign s_col_idx = CW'(s_column);
    assign col_ok    = (32'(s_column) < LINE_WIDTH);
    assign hp_raddr  = (state_reg == affc_pkg::ST_IDLE) ? s_col_idx : col_reg;
    assign hp        = hp_q[7:0];
    assign age       = hp_q[AW+7:8];
    assign age_inc   = (age <= AW'(SAMPLE_LINES)) ? age + AW'(1) : age;
    assign issue     = (state_reg == affc_pkg::ST_SCAN) && (cnt_reg < n_reg);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        row_next      = row_reg;
        cmd_next      = cmd_reg;
        col_next      = col_reg;
        colp_next     = colp_reg;
        pix_next      = pix_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        srow_next     = srow_reg;
        rd_vld_next   = issue;
        rd_age_next   = cnt_reg + GW'(1);
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        g0_next       = g0_reg;
        g1_next       = g1_reg;
        g2_next       = g2_reg;
        zero_age_next = zero_age_reg;
        s_next        = s_reg;
        res_next      = res_reg;
        hist_we       = 1'b0;
        hist_waddr    = clr_reg;
        hist_wdata    = affc_pkg::FULL_SCALE;
        hp_we         = 1'b0;
        hp_waddr      = col_reg;
        hp_wdata      = {AW'(affc_pkg::AGE_INIT), affc_pkg::FULL_SCALE};
        tbl_we        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;

        if (issue) begin
            cnt_next  = cnt_reg + GW'(1);
            srow_next = (srow_reg == '0) ? RW'(SAMPLE_LINES - 1) : srow_reg - RW'(1);
        end
        if (rd_vld_reg) begin
            if (hist_q > t0_reg) begin
                t2_next = t1_reg; g2_next = g1_reg;
                t1_next = t0_reg; g1_next = g0_reg;
                t0_next = hist_q; g0_next = rd_age_reg;
            end else if (hist_q > t1_reg) begin
                t2_next = t1_reg; g2_next = g1_reg;
                t1_next = hist_q; g1_next = rd_age_reg;
            end else if (hist_q > t2_reg) begin
                t2_next = hist_q; g2_next = rd_age_reg;
            end
        end

        unique case (state_reg)
            affc_pkg::ST_CLEAR: begin
                hist_we  = 1'b1;
                hp_waddr = CW'(clr_reg);
                hp_we    = (clr_reg[HAW-1:CW] == '0);
                clr_next = clr_reg + HAW'(1);
                if (clr_reg == HAW'(HD - 1)) begin
                    state_next = affc_pkg::ST_IDLE;
                end
            end
            affc_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next  = s_command;
                    col_next  = s_col_idx;
                    colp_next = s_column;
                    pix_next  = s_pixel;
                    n_next    = (32'(s_recent_lines) < SAMPLE_LINES) ?
                                GW'(s_recent_lines) : GW'(SAMPLE_LINES);
                    if (s_command == affc_pkg::CMD_SAMPLE && s_line_start) begin
                        row_next = (32'(row_reg) + 1 >= SAMPLE_LINES) ?
                                   '0 : row_reg + RW'(1);
                    end
                    unique case (s_command) inside
                        affc_pkg::CMD_WR_TABLE: begin
                            tbl_we = 1'b1;
                        end
                        affc_pkg::CMD_SAMPLE, affc_pkg::CMD_CORRECT,
                        affc_pkg::CMD_READ_HP, affc_pkg::CMD_PEAK: begin
                            if (col_ok) begin
                                state_next = affc_pkg::ST_DECIDE;
                                if (s_command == affc_pkg::CMD_SAMPLE) begin
                                    hist_we    = 1'b1;
                                    hist_waddr = {row_next, s_col_idx};
                                    hist_wdata = s_pixel;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            affc_pkg::ST_DECIDE: begin
                cnt_next  = '0;
                srow_next = row_reg;
                t0_next = '0; t1_next = '0; t2_next = '0;
                g0_next = '0; g1_next = '0; g2_next = '0;
                unique case (cmd_reg)
                    affc_pkg::CMD_SAMPLE: begin
                        state_next = affc_pkg::ST_IDLE;
                        hp_we      = 1'b1;
                        hp_wdata   = {AW'(0), hp};
                        if (pix_reg < hp) begin
                            hp_wdata = {age_inc, hp};
                            if (age_inc > AW'(SAMPLE_LINES) && corr_on_reg) begin
                                hp_we         = 1'b0;
                                n_next        = GW'(SAMPLE_LINES);
                                zero_age_next = 1'b0;
                                state_next    = affc_pkg::ST_SCAN;
                            end
                        end else if ({1'b0, pix_reg} > {1'b0, hp} + affc_pkg::HP_MARGIN) begin
                            if (corr_on_reg) begin
                                hp_we         = 1'b0;
                                n_next        = GW'(SAMPLE_LINES);
                                zero_age_next = 1'b1;
                                state_next    = affc_pkg::ST_SCAN;
                            end
                        end
                    end
                    affc_pkg::CMD_CORRECT: begin
                        if (!corr_on_reg) begin
                            res_next   = pix_reg;
                            state_next = affc_pkg::ST_OUT;
                        end else if (hp < affc_pkg::HP_MIN || pix_reg >= hp) begin
                            s_next     = affc_pkg::FULL_SCALE;
                            state_next = affc_pkg::ST_LOOKUP;
                        end else begin
                            div_start  = 1'b1;
                            state_next = affc_pkg::ST_DIV;
                        end
                    end
                    affc_pkg::CMD_READ_HP: begin
                        res_next   = hp;
                        state_next = affc_pkg::ST_OUT;
                    end
                    default: begin
                        state_next = affc_pkg::ST_SCAN;
                    end
                endcase
            end
            affc_pkg::ST_SCAN: begin
                if (!issue && !rd_vld_reg) begin
                    if (cmd_reg == affc_pkg::CMD_SAMPLE) begin
                        hp_we      = 1'b1;
                        hp_wdata   = {(zero_age_reg ? AW'(0) : AW'(g2_reg)), t2_reg};
                        state_next = affc_pkg::ST_IDLE;
                    end else begin
                        res_next   = t0_reg;
                        state_next = affc_pkg::ST_OUT;
                    end
                end
            end
            affc_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    s_next     = quot;
                    state_next = affc_pkg::ST_LOOKUP;
                end
            end
            affc_pkg::ST_LOOKUP: begin
                state_next = affc_pkg::ST_CORR;
            end
            affc_pkg::ST_CORR: begin
                res_next   = affc_pkg::FULL_SCALE - (comp_on_reg ? tbl_q : s_reg);
                state_next = affc_pkg::ST_OUT;
            end
            affc_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = affc_pkg::ST_IDLE;
                end
            end
            default: state_next = affc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= affc_pkg::ST_CLEAR;
            clr_reg     <= '0;
            row_reg     <= RW'(SAMPLE_LINES - 1);
            corr_on_reg <= 1'b1;
            comp_on_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            row_reg    <= row_next;
            rd_vld_reg <= rd_vld_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == affc_pkg::REG_CORRECTION) begin
                    corr_on_reg <= cfg_data;
                end else begin
                    comp_on_reg <= cfg_data;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        cmd_reg      <= cmd_next;
        col_reg      <= col_next;
        colp_reg     <= colp_next;
        pix_reg      <= pix_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        srow_reg     <= srow_next;
        rd_age_reg   <= rd_age_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        g0_reg       <= g0_next;
        g1_reg       <= g1_next;
        g2_reg       <= g2_next;
        zero_age_reg <= zero_age_next;
        s_reg        <= s_next;
        res_reg      <= res_next;
        if (out_load) begin
            m_col_reg <= colp_reg;
            m_val_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q <= hist_mem[{srow_reg, col_reg}];
    end

    always_ff @(posedge aclk) begin
        if (hp_we) begin
            hp_mem[hp_waddr] <= hp_wdata;
        end
        hp_q <= hp_mem[hp_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[s_table_index] <= s_pixel;
        end
        tbl_q <= tbl_mem[s_reg];
    end

    assign m_valid         = m_valid_reg;
    assign m_result_column = m_col_reg;
    assign m_result_value  = m_val_reg;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == affc_pkg::ST_CLEAR) |-> !s_ready)
        else $error("transfer possible during clearing pass");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == affc_pkg::ST_SCAN) |-> (cnt_reg <= n_reg))
        else $error("history scan overran its line count");
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == affc_pkg::ST_DIV))
        else $error("divider finished outside division state");
`endif

endmodule

`default_nettype wire

// ----- tb/adaptive_flat_field_correction_top_tb.sv -----
// ----------------------------------------------------------------------------
// Adaptive flat-field correction - testbench
// Drives sample, correct, table, high-point and peak commands from a queue.
// The block is run under several register settings and idling patterns.
// Every result is compared against an in-bench model of the column history,
// high-point tracking and the correction arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module adaptive_flat_field_correction_top_tb;

    localparam int NCOL     = 2048;
    localparam int NLINES   = 16;
    localparam int IDLE_LIM = 200000;

    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    typedef struct {
        logic [2:0]  command;
        logic [10:0] column;
        logic [7:0]  pixel;
        logic        line_start;
        logic [4:0]  recent_lines;
        logic [7:0]  table_index;
        bit          drain;
    } pix_item_t;

    typedef struct {
        logic [10:0] column;
        logic [7:0]  value;
    } pix_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = '0;
    logic [10:0] s_column = '0;
    logic [7:0]  s_pixel = '0;
    logic        s_line_start = 1'b0;
    logic [4:0]  s_recent_lines = '0;
    logic [7:0]  s_table_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_result_column;
    logic [7:0]  m_result_value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;

    adaptive_flat_field_correction_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_column(s_column), .s_pixel(s_pixel), .s_line_start(s_line_start),
        .s_recent_lines(s_recent_lines), .s_table_index(s_table_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_column(m_result_column), .m_result_value(m_result_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    pix_item_t   pending_items[$];
    pix_result_t expected_results[$];
    int          mismatches = 0;
    int          idle_mode = 0;
    int          idle_count = 0;

    logic [7:0] hist [NLINES][NCOL];
    logic [7:0] high_point [NCOL];
    int         hp_age [NCOL];
    logic [7:0] comp_table [256];
    int         wr_row;
    bit         corr_on, comp_on;

    initial begin
        for (int r = 0; r < NLINES; r++)
            for (int c = 0; c < NCOL; c++) hist[r][c] = 8'd255;
        for (int c = 0; c < NCOL; c++) begin
            high_point[c] = 8'd255;
            hp_age[c] = affc_pkg::AGE_INIT;
        end
        wr_row = NLINES - 1;
        corr_on = 1'b1;
        comp_on = 1'b0;
    end

    task automatic rescan_high_point(input int col);
        int row, v;
        int t0, t1, t2, g0, g1, g2;
        row = wr_row;
        t0 = 0; t1 = 0; t2 = 0; g0 = 0; g1 = 0; g2 = 0;
        for (int a = 1; a <= NLINES; a++) begin
            v = hist[row][col];
            if (v > t0) begin
                t2 = t1; g2 = g1; t1 = t0; g1 = g0; t0 = v; g0 = a;
            end else if (v > t1) begin
                t2 = t1; g2 = g1; t1 = v; g1 = a;
            end else if (v > t2) begin
                t2 = v; g2 = a;
            end
            row = (row == 0) ? NLINES - 1 : row - 1;
        end
        high_point[col] = t2[7:0];
        hp_age[col] = g2;
    endtask

    task automatic predict_pixel(input pix_item_t it);
        int col, pix, hp, s, val, n, row;
        pix_result_t res;
        col = it.column;
        pix = it.pixel;
        val = 0;
        if (it.command == affc_pkg::CMD_SAMPLE && it.line_start)
            wr_row = (wr_row + 1 >= NLINES) ? 0 : wr_row + 1;
        if (it.command == affc_pkg::CMD_WR_TABLE) begin
            comp_table[it.table_index] = it.pixel;
            return;
        end
        if (it.command > affc_pkg::CMD_PEAK) return;
        hp = high_point[col];
        if (it.command == affc_pkg::CMD_SAMPLE) begin
            hist[wr_row][col] = it.pixel;
            if (pix < hp) begin
                if (hp_age[col] <= NLINES) hp_age[col]++;
                if (hp_age[col] > NLINES && corr_on) rescan_high_point(col);
            end else if (pix > hp + affc_pkg::HP_MARGIN) begin
                if (corr_on) rescan_high_point(col);
                hp_age[col] = 0;
            end else begin
                hp_age[col] = 0;
            end
            return;
        end
        if (it.command == affc_pkg::CMD_CORRECT) begin
            if (!corr_on) begin
                val = pix;
            end else begin
                if (hp < affc_pkg::HP_MIN || pix >= hp) s = 255;
                else s = (510 * pix + hp) / (2 * hp);
                if (comp_on) s = comp_table[s];
                val = affc_pkg::FULL_SCALE - s;
            end
        end else if (it.command == affc_pkg::CMD_READ_HP) begin
            val = hp;
        end else begin
            n = (it.recent_lines < NLINES) ? it.recent_lines : NLINES;
            row = wr_row;
            for (int k = 0; k < n; k++) begin
                if (hist[row][col] > val) val = hist[row][col];
                row = (row == 0) ? NLINES - 1 : row - 1;
            end
        end
        res.column = it.column;
        res.value = val[7:0];
        expected_results.insert(expected_results.size(), res);
    endtask

    // input driver
    always @(posedge aclk) begin
        bit        load;
        pix_item_t nxt;
        load = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) predict_pixel('{s_command, s_column, s_pixel,
                s_line_start, s_recent_lines, s_table_index, 1'b0});
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 &&
                    !(idle_mode == 0 && $urandom_range(99) < 16) &&
                    !(idle_mode == 1 && $urandom_range(99) < 87) &&
                    (!pending_items[0].drain || expected_results.size() == 0)) begin
                    nxt = pending_items.pop_front();
                    load = 1'b1;
                    s_command      <= nxt.command;
                    s_column       <= nxt.column;
                    s_pixel        <= nxt.pixel;
                    s_line_start   <= nxt.line_start;
                    s_recent_lines <= nxt.recent_lines;
                    s_table_index  <= nxt.table_index;
                end
                s_valid <= load;
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // result monitor and watchdog
    always @(posedge aclk) begin
        pix_result_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIM) begin
                $display("Mismatches found");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer, column", m_result_column, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_result_column !== want.column)
                        report_mismatch("result_column", m_result_column, want.column);
                    if (m_result_value !== want.value)
                        report_mismatch("result_value", m_result_value, want.value);
                end
            end
        end
        m_ready <= (idle_mode == 0) ? ($urandom_range(99) >= 87) :
                   (idle_mode == 1) ? ($urandom_range(99) >= 16) : 1'b1;
    end

    task automatic queue_item(input logic [2:0] cmd, input int col, input int pix,
                              input bit ls, input int nl, input int ti);
        pix_item_t it;
        it.command = cmd;
        it.column = col[10:0];
        it.pixel = pix[7:0];
        it.line_start = ls;
        it.recent_lines = nl[4:0];
        it.table_index = ti[7:0];
        it.drain = 1'b0;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (NLINES * 3) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == affc_pkg::REG_CORRECTION) corr_on = val;
        else comp_on = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic queue_random_lines(input int count);
        int start, p, r, c;
        start = pending_items.size();
        while (pending_items.size() - start < count) begin
            for (int c0 = 0; c0 < 8; c0++) begin
                r = $urandom_range(99);
                p = (r < 60) ? $urandom_range(255, 190) :
                    (r < 80) ? $urandom_range(189, 40) :
                    (r < 90) ? $urandom_range(27, 0) : $urandom_range(255);
                queue_item(affc_pkg::CMD_SAMPLE, c0, p, c0 == 0, 0, 0);
            end
            repeat ($urandom_range(8, 3)) begin
                c = $urandom_range(7);
                r = $urandom_range(99);
                if (r < 55)
                    queue_item(affc_pkg::CMD_CORRECT, c, $urandom_range(255), 0, 0, 0);
                else if (r < 70)
                    queue_item(affc_pkg::CMD_READ_HP, c, 0, 0, 0, 0);
                else if (r < 85)
                    queue_item(affc_pkg::CMD_PEAK, c, 0, 0, $urandom_range(31), 0);
                else if (r < 92)
                    queue_item(affc_pkg::CMD_WR_TABLE, 0, $urandom_range(255), 0, 0,
                               $urandom_range(255));
                else
                    queue_item(3'($urandom_range(7)), $urandom_range(2047),
                               $urandom_range(255), 1'($urandom_range(1)),
                               $urandom_range(31), $urandom_range(255));
            end
        end
    endtask

    initial begin
        bit corr_set [6] = '{1, 1, 0, 1, 0, 1};
        bit comp_set [6] = '{0, 1, 1, 1, 0, 0};
        pix_item_t barrier;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 256; i++)
            queue_item(affc_pkg::CMD_WR_TABLE, 0, $urandom_range(255), 0, 0, i);
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            idle_mode = ph / 2;
            write_register(affc_pkg::REG_CORRECTION, corr_set[ph]);
            write_register(affc_pkg::REG_COMPENSATION, comp_set[ph]);
            if (ph == 0) begin
                queue_item(affc_pkg::CMD_READ_HP, 0, 0, 0, 0, 0);
                queue_item(affc_pkg::CMD_PEAK, 0, 0, 0, 0, 0);
                queue_item(affc_pkg::CMD_PEAK, 2047, 0, 0, 31, 0);
                queue_item(affc_pkg::CMD_CORRECT, 0, 0, 0, 0, 0);
                queue_item(affc_pkg::CMD_CORRECT, 2047, 255, 0, 0, 0);
                queue_item(affc_pkg::CMD_CORRECT, 0, 254, 0, 0, 0);
                // dark column: ages out to a high point below the minimum
                for (int l = 0; l < 18; l++) queue_item(affc_pkg::CMD_SAMPLE, 1, 0, 1, 0, 0);
                queue_item(affc_pkg::CMD_READ_HP, 1, 0, 0, 0, 0);
                queue_item(affc_pkg::CMD_CORRECT, 1, 0, 0, 0, 0);
                queue_item(affc_pkg::CMD_SAMPLE, 1, 255, 0, 0, 0);
                queue_item(affc_pkg::CMD_READ_HP, 1, 0, 0, 0, 0);
                queue_item(affc_pkg::CMD_PEAK, 1, 0, 0, 16, 0);
                queue_item(CMD_SPARE_A, 0, 0, 0, 0, 0);
                queue_item(CMD_SPARE_B, 2047, 255, 1, 31, 255);
                queue_item(CMD_SPARE_C, 0, 0, 0, 0, 0);
            end
            queue_random_lines(85);
            barrier.command = affc_pkg::CMD_READ_HP;
            barrier.column = 11'($urandom_range(7));
            barrier.pixel = '0;
            barrier.line_start = 1'b0;
            barrier.recent_lines = '0;
            barrier.table_index = '0;
            barrier.drain = 1'b1;
            pending_items.insert(pending_items.size(), barrier);
            queue_random_lines(85);
        end
        wait_drained();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
